// ===== design/sm3_pkg.sv =====
package sm3_pkg;

  localparam int BlockBytes = 64;
  localparam int LenPos = 56;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [9:0] BlockBits = 10'd512;
  localparam int QueueDepth = 4;

  localparam logic [31:0] TjLow = 32'h79cc4519;
  localparam logic [31:0] TjHigh = 32'h7a879d8a;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sm3_item_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } sm3_hs_t;

  function automatic logic [255:0] sm3_iv();
    return {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
            32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] x, logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(logic [31:0] x);
    return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(logic [31:0] x);
    return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
  endfunction

endpackage

// ===== design/sm3_ram.sv =====
module sm3_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/sm3_queue.sv =====
module sm3_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sm3_pkg::sm3_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output sm3_pkg::sm3_item_t out_item
);
  import sm3_pkg::*;

  localparam int Aw = $clog2(QueueDepth);

  sm3_item_t    slots [QueueDepth];
  logic [Aw-1:0] wptr;
  logic [Aw-1:0] rptr;
  logic [Aw:0]   count;
  logic          push;
  logic          pop;

  assign in_ready = count != (Aw + 1)'(QueueDepth);
  assign out_valid = count != '0;
  assign out_item = slots[rptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (Aw + 1)'(push) - (Aw + 1)'(pop);
    end
  end
endmodule

// ===== design/sm3_compress.sv =====
module sm3_round_engine (
  input  logic         clk,
  input  logic         rst,
  input  sm3_pkg::sm3_item_t item,
  input  logic         item_valid,
  output logic         item_ready,
  output logic         res_valid,
  input  logic         res_ready,
  output logic [255:0] res_digest
);
  import sm3_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_PAD   = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t        state;
  logic [5:0]    fill;
  logic [63:0]   bit_length;
  logic [63:0]   total;
  logic [255:0]  cv;
  logic [31:0]   wr [8];
  logic [31:0]   win [16];
  logic [6:0]    cnt;
  logic          final_pass;
  logic          pad_again;
  logic          padding;
  logic          in_pad;

  logic          ram_we;
  logic [5:0]    ram_waddr;
  logic [7:0]    ram_wdata;
  logic [5:0]    ram_raddr;
  logic [7:0]    ram_rdata;

  sm3_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign item_ready = state == S_IDLE;
  assign res_valid = state == S_OUT;
  assign res_digest = cv;
  assign ram_raddr = cnt[5:0];

  logic [31:0] wnew;
  logic [5:0]  j;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;

  always_comb begin
    j = cnt[5:0];
    wnew = perm1(win[0] ^ win[7] ^ rol32(win[13], 5'd15)) ^ rol32(win[3], 5'd7) ^ win[10];
    tj = (j < 6'd16) ? TjLow : TjHigh;
    a12 = rol32(wr[0], 5'd12);
    ss1 = rol32(a12 + wr[4] + rol32(tj, j[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = wr[0] ^ wr[1] ^ wr[2];
      gg = wr[4] ^ wr[5] ^ wr[6];
    end else begin
      ff = (wr[0] & wr[1]) | (wr[0] & wr[2]) | (wr[1] & wr[2]);
      gg = (wr[4] & wr[5]) | (~wr[4] & wr[6]);
    end
    tt1 = ff + wr[3] + ss2 + (win[0] ^ win[4]);
    tt2 = gg + wr[7] + ss1 + win[0];
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = fill;
    ram_wdata = item.data_byte;
    if (state == S_IDLE && item_valid && item.has_byte) begin
      ram_we = 1'b1;
    end else if (state == S_PAD) begin
      ram_we = 1'b1;
      if (padding) begin
        ram_wdata = PadMark;
      end else if (fill >= 6'(LenPos) && !pad_again) begin
        ram_wdata = total[63 - 8 * (fill[2:0]) -: 8];
      end else begin
        ram_wdata = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      bit_length <= '0;
      cv <= sm3_iv();
      cnt <= '0;
      final_pass <= 1'b0;
      pad_again <= 1'b0;
      padding <= 1'b0;
      in_pad <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.has_byte) begin
              fill <= fill + 1'b1;
            end
            final_pass <= item.last;
            if (item.has_byte && fill == 6'd63) begin
              cnt <= '0;
              state <= S_LOAD;
            end else if (item.last) begin
              total <= bit_length + {55'd0, fill + 6'(item.has_byte), 3'd0};
              if (item.has_byte) fill <= fill + 1'b1;
              padding <= 1'b1;
              in_pad <= 1'b1;
              pad_again <= (fill + 6'(item.has_byte)) >= 6'(LenPos);
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          padding <= 1'b0;
          fill <= fill + 1'b1;
          if (fill == 6'd63) begin
            cnt <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt <= cnt + 1'b1;
          if (cnt != '0) begin
            win[cnt[5:2] - 4'd0 - (cnt[1:0] == 2'd0 ? 4'd1 : 4'd0)] <=
              {win[cnt[5:2] - (cnt[1:0] == 2'd0 ? 4'd1 : 4'd0)][23:0], ram_rdata};
          end
          if (cnt == 7'd64) begin
            for (int i = 0; i < 8; i++) wr[i] <= cv[255 - 32 * i -: 32];
            cnt <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          wr[0] <= tt1;
          wr[1] <= wr[0];
          wr[2] <= rol32(wr[1], 5'd9);
          wr[3] <= wr[2];
          wr[4] <= perm0(tt2);
          wr[5] <= wr[4];
          wr[6] <= rol32(wr[5], 5'd19);
          wr[7] <= wr[6];
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= wnew;
          cnt <= cnt + 1'b1;
          if (cnt == 7'd63) state <= S_DONE;
        end
        S_DONE: begin
          cv <= cv ^ {wr[0], wr[1], wr[2], wr[3], wr[4], wr[5], wr[6], wr[7]};
          fill <= '0;
          if (!in_pad) begin
            bit_length <= bit_length + {54'd0, BlockBits};
            if (final_pass) begin
              total <= bit_length + {54'd0, BlockBits};
              padding <= 1'b1;
              pad_again <= 1'b0;
              in_pad <= 1'b1;
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end else if (pad_again) begin
            pad_again <= 1'b0;
            state <= S_PAD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            cv <= sm3_iv();
            bit_length <= '0;
            fill <= '0;
            final_pass <= 1'b0;
            in_pad <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/sm3_hash_engine_core.sv =====
// SM3 hash engine. Message bytes arrive on the input channel, one request
// per byte, with has_byte marking a real byte and last ending the message.
// Requests are registered in a four-entry queue and pass from it into the
// compression engine, which takes them while it is idle.
// A byte that does not complete a block is written to the buffer memory. The
// byte that completes a block starts a compression: the message is loaded
// from the buffer memory through its single read port, then 64 rounds and
// one feed-forward step follow. The last request pads the block one byte
// per cycle up to byte 63 and compresses; when fewer than nine bytes are
// free, a second padding block and a second compression follow.
// The digest then appears on the output channel and holds until taken.
// While the receiver stalls, the engine waits with the digest and the
// queue fills, then input ready drops. Reset loads the standard IV and
// clears the length and fill count; no clearing pass is needed.
module sm3_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_w0,
  output logic [31:0] digest_w1,
  output logic [31:0] digest_w2,
  output logic [31:0] digest_w3,
  output logic [31:0] digest_w4,
  output logic [31:0] digest_w5,
  output logic [31:0] digest_w6,
  output logic [31:0] digest_w7
);
  import sm3_pkg::*;

  sm3_item_t    in_item;
  sm3_item_t    q_item;
  sm3_hs_t      q_hs;
  logic [255:0] digest;

  assign in_item = '{data_byte: data_byte, has_byte: has_byte, last: last};

  sm3_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(q_hs.valid), .out_ready(q_hs.ready),
    .out_item(q_item)
  );

  sm3_round_engine u_core (
    .clk(clk), .rst(rst), .item(q_item), .item_valid(q_hs.valid),
    .item_ready(q_hs.ready), .res_valid(out_valid), .res_ready(out_ready),
    .res_digest(digest)
  );

  assign {digest_w0, digest_w1, digest_w2, digest_w3,
          digest_w4, digest_w5, digest_w6, digest_w7} = digest;
endmodule

// ===== design/sm3_checker.sv =====
module sm3_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] digest_w0
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_w0))
    else $error("digest dropped while stalled");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_ready_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("queue not ready after reset");
endmodule

bind sm3_hash_engine_core sm3_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .digest_w0(digest_w0)
);
